FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: always");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implies");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next");

`endif

FILE: hw/rtl/dske_pkg.sv
`timescale 1ns / 1ps

package dske_pkg;

	localparam int unsigned YearW  = 12;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;

	localparam logic [YearW-1:0] YearMinReset = 12'd2000;
	localparam logic [YearW-1:0] YearMaxReset = 12'd2100;

	// 25 * Inv25 == 1 mod 4096; y is a multiple of 25 iff y * Inv25 mod 4096 <= 4095 / 25
	localparam logic [YearW-1:0] Inv25    = 12'd3113;
	localparam logic [YearW-1:0] Div25Max = 12'd163;

	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthApr = 4'd4;
	localparam logic [MonthW-1:0] MonthJun = 4'd6;
	localparam logic [MonthW-1:0] MonthSep = 4'd9;
	localparam logic [MonthW-1:0] MonthNov = 4'd11;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;
	localparam logic [MonthW-1:0] MonthJan = 4'd1;

	localparam logic [DayW-1:0] DaysFebLeap = 5'd29;
	localparam logic [DayW-1:0] DaysFeb     = 5'd28;
	localparam logic [DayW-1:0] DaysShort   = 5'd30;
	localparam logic [DayW-1:0] DaysLong    = 5'd31;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_UP    = 3'd1,
		OP_DOWN  = 3'd2,
		OP_LEFT  = 3'd3,
		OP_RIGHT = 3'd4,
		OP_OK    = 3'd5,
		OP_BACK  = 3'd6,
		OP_NOP   = 3'd7
	} dske_op_t;

	typedef enum logic [1:0] {
		FOCUS_YEAR  = 2'd0,
		FOCUS_MONTH = 2'd1,
		FOCUS_DAY   = 2'd2
	} dske_focus_t;

	localparam logic [1:0] FocusInvalid = 2'd3;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		dske_focus_t       focus;
	} dske_state_t;

	typedef struct packed {
		logic commit;
		logic leave;
	} dske_flags_t;

	// Gregorian rule: divisible by 4, and not by 100 unless by 400
	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [YearW-1:0] prod;
		logic div25;
		prod  = YearW'(y * Inv25);
		div25 = (prod <= Div25Max);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] len;
		if (m == MonthFeb) begin
			len = leap ? DaysFebLeap : DaysFeb;
		end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
			len = DaysShort;
		end else begin
			len = DaysLong;
		end
		return len;
	endfunction

endpackage

FILE: hw/rtl/dske_step.sv
`timescale 1ns / 1ps

module dske_step (
	input  dske_pkg::dske_state_t        cur,
	input  dske_pkg::dske_op_t           op,
	input  logic [dske_pkg::YearW-1:0]   load_year,
	input  logic [dske_pkg::MonthW-1:0]  load_month,
	input  logic [dske_pkg::DayW-1:0]    load_day,
	input  logic [dske_pkg::YearW-1:0]   year_min,
	input  logic [dske_pkg::YearW-1:0]   year_max,
	output dske_pkg::dske_state_t        nxt,
	output dske_pkg::dske_flags_t        flags
);
	import dske_pkg::*;

	logic              up;
	logic [YearW-1:0]  year_step;
	logic [MonthW-1:0] month_step;
	logic [DayW-1:0]   day_step;
	logic [DayW-1:0]   len_cur;
	logic [DayW-1:0]   len_yr;
	logic [DayW-1:0]   len_mo;
	logic              leap_cur;
	logic              leap_yr;

	assign up = (op == OP_UP);

	always_comb begin
		if (up) begin
			year_step = (cur.year >= year_max) ? year_min : YearW'(cur.year + 12'd1);
		end else begin
			year_step = (cur.year > year_min) ? YearW'(cur.year - 12'd1) : year_max;
		end
	end

	always_comb begin
		if (up) begin
			month_step = (cur.month >= MonthDec) ? MonthJan : MonthW'(cur.month + 4'd1);
		end else if (cur.month <= MonthJan || cur.month > MonthDec) begin
			month_step = MonthDec;
		end else begin
			month_step = MonthW'(cur.month - 4'd1);
		end
	end

	assign leap_cur = is_leap(cur.year);
	assign leap_yr  = is_leap(year_step);
	assign len_cur  = month_len(cur.month, leap_cur);
	assign len_yr   = month_len(cur.month, leap_yr);
	assign len_mo   = month_len(month_step, leap_cur);

	always_comb begin
		if (up) begin
			day_step = (cur.day >= len_cur) ? 5'd1 : DayW'(cur.day + 5'd1);
		end else if (cur.day <= 5'd1 || cur.day > len_cur) begin
			day_step = len_cur;
		end else begin
			day_step = DayW'(cur.day - 5'd1);
		end
	end

	always_comb begin
		nxt   = cur;
		flags = '0;
		unique case (op)
			OP_LOAD: begin
				nxt.year  = load_year;
				nxt.month = load_month;
				nxt.day   = load_day;
			end
			OP_UP, OP_DOWN: begin
				unique case (cur.focus)
					FOCUS_YEAR: begin
						nxt.year = year_step;
						nxt.day  = (cur.day > len_yr) ? len_yr : cur.day;
					end
					FOCUS_MONTH: begin
						nxt.month = month_step;
						nxt.day   = (cur.day > len_mo) ? len_mo : cur.day;
					end
					FOCUS_DAY: begin
						nxt.day = day_step;
					end
					default: begin
					end
				endcase
			end
			OP_LEFT: begin
				if (cur.focus == FOCUS_MONTH) nxt.focus = FOCUS_YEAR;
				else if (cur.focus == FOCUS_DAY) nxt.focus = FOCUS_MONTH;
			end
			OP_RIGHT: begin
				if (cur.focus == FOCUS_YEAR) nxt.focus = FOCUS_MONTH;
				else if (cur.focus == FOCUS_MONTH) nxt.focus = FOCUS_DAY;
			end
			OP_OK: begin
				flags.commit = 1'b1;
				flags.leave  = 1'b1;
			end
			OP_BACK: begin
				flags.leave = 1'b1;
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/date_setting_key_editor.sv
// Date editor driven by key requests.
// Input channel (in_valid/in_ready): operation plus the clock date used by load.
// Output channel (out_valid/out_ready): one result per request, carrying the
// date and focus held after it, with commit and leave flags.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// year_min, 1 writes year_max; write only while no request is in flight.
// A result appears in the cycle after its request is taken. Throughput: one
// request per cycle while not stalled; the editor state is updated in the
// same cycle as the request and the result is held in an output register.
// Stall: while the output holds an untaken result, in_ready follows out_ready,
// so a request is taken in the same cycle the held result leaves.
// Reset: date and focus clear to zero (year focused), year_min to 2000,
// year_max to 2100, output empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module date_setting_key_editor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [dske_pkg::YearW-1:0]  load_year,
	input  logic [dske_pkg::MonthW-1:0] load_month,
	input  logic [dske_pkg::DayW-1:0]   load_day,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [dske_pkg::YearW-1:0]  shown_year,
	output logic [dske_pkg::MonthW-1:0] shown_month,
	output logic [dske_pkg::DayW-1:0]   shown_day,
	output logic [1:0]  focus_field,
	output logic        commit,
	output logic        leave
);
	import dske_pkg::*;

	localparam logic CfgYearMin = 1'b0;
	localparam logic CfgYearMax = 1'b1;

	logic [YearW-1:0] year_min_q;
	logic [YearW-1:0] year_max_q;
	dske_state_t      state_q;
	dske_state_t      state_nxt;
	dske_flags_t      flags_nxt;
	dske_state_t      res_q;
	dske_flags_t      res_flags_q;
	logic             out_valid_q;
	logic             accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	dske_step u_step (
		.cur        (state_q),
		.op         (dske_op_t'(operation)),
		.load_year  (load_year),
		.load_month (load_month),
		.load_day   (load_day),
		.year_min   (year_min_q),
		.year_max   (year_max_q),
		.nxt        (state_nxt),
		.flags      (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_min_q <= YearMinReset;
			year_max_q <= YearMaxReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgYearMin: year_min_q <= cfg_data;
				CfgYearMax: year_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) state_q <= state_nxt;
			if (accept) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q       <= state_nxt;
			res_flags_q <= flags_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign shown_year  = res_q.year;
	assign shown_month = res_q.month;
	assign shown_day   = res_q.day;
	assign focus_field = res_q.focus;
	assign commit      = res_flags_q.commit;
	assign leave       = res_flags_q.leave;

	`ASSERT_ALWAYS(a_focus_legal, clk, arst_n, state_q.focus != FocusInvalid)
	`ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, out_valid)
	`ASSERT_IMPLIES(a_commit_leaves, clk, arst_n, out_valid && commit, leave)
	`ASSERT_NEXT(a_day_step_nonzero, clk, arst_n,
		accept && state_q.focus == FOCUS_DAY &&
		(operation == OP_UP || operation == OP_DOWN), shown_day != 5'd0)

endmodule
